>>> rtl/core/bitmap_find_next_set_bit_core_defines.svh
// Assertion macros for the bitmap find-next-set-bit core.
// Relies on the including module having clk and rst_n in scope.
`ifndef BITMAP_FIND_NEXT_SET_BIT_CORE_DEFINES_SVH
`define BITMAP_FIND_NEXT_SET_BIT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bfnsb_pkg.sv
// Types and constants shared by the bitmap find-next-set-bit core.
// Holds the transfer payload structs, operation codes and register map.
package bfnsb_pkg;

    localparam int OP_W        = 2;
    localparam int WIDX_W      = 6;
    localparam int DATA_W      = 64;
    localparam int POS_W       = 12;
    localparam int START_W     = POS_W + 1;
    localparam int WCOUNT_W    = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND_FIRST = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND_NEXT  = 2'd2;

    // Register index is paddr[2]; only index 0 exists.
    localparam logic REG_WORD_COUNT = 1'b0;

    localparam logic [WCOUNT_W-1:0] WORD_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WIDX_W-1:0] word_index;
        logic [DATA_W-1:0] word_data;
        logic [POS_W-1:0]  prev_bit;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  bit_position;
    } out_item_t;

endpackage

>>> rtl/core/bitmap_find_next_set_bit_core.sv
// Bitmap of MAX_WORDS words of WORD_BITS bits in one synchronous memory. A write or an unused
// opcode gives its result without a scan; a search reads one memory word per cycle, up to the
// number of words in use, and stops at the first word holding a set bit at or above the start
// position. A find-next scans from word 0. After reset the block sweeps zeros through every
// memory word and takes no item during that pass; configuration writes are taken at any time.
`include "bitmap_find_next_set_bit_core_defines.svh"

module bitmap_find_next_set_bit_core
    import bfnsb_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int MAX_WORDS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW0    = $clog2(MAX_WORDS + 1);
    localparam int CNT_W  = (CW0 > WCOUNT_W) ? CW0 : WCOUNT_W;
    localparam int PW0    = $clog2(MAX_WORDS * WORD_BITS);
    localparam int PW     = (PW0 > 0) ? PW0 : 1;
    localparam int XW     = ((PW > START_W) ? PW : START_W) + 1;
    localparam int SW     = $clog2(WORD_BITS);
    localparam int SUM_W  = (PW > POS_W) ? PW : POS_W;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_idx_reg, clr_idx_next;
    logic [AW-1:0]          chk_idx_reg, chk_idx_next;
    logic [PW-1:0]          base_reg, base_next;
    logic [START_W-1:0]     start_reg, start_next;
    logic [WCOUNT_W-1:0]    word_count_reg, word_count_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;
    logic [WORD_BITS-1:0]   rd_data_reg;

    logic [WORD_BITS-1:0]   mem_words [MAX_WORDS];

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;

    logic                   in_xfer;
    logic                   out_free;
    logic                   scan_step;
    logic                   is_search;
    logic [CNT_W-1:0]       used;
    logic [CNT_W-1:0]       widx_ext;
    logic [CNT_W-1:0]       next_idx_ext;
    logic signed [XW-1:0]   rel;
    logic [WORD_BITS-1:0]   start_mask;
    logic [WORD_BITS-1:0]   masked;
    logic [WORD_BITS-1:0]   low_onehot;
    logic [SW-1:0]          bit_idx;
    logic [SUM_W-1:0]       pos_sum;
    logic                   cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WORD_COUNT) ? APB_DATA_W'(word_count_reg) : '0;

    always_comb
    begin
        word_count_next = word_count_reg;
        if (cfg_write && (paddr[2] == REG_WORD_COUNT))
        begin
            word_count_next = pwdata[WCOUNT_W-1:0];
        end
    end

    // Words in use, capped at the store depth.
    assign used = (CNT_W'(word_count_reg) > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS)
                                                               : CNT_W'(word_count_reg);

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_xfer   = in_valid && !in_stall;
    assign scan_step = (state_reg == S_SCAN) && out_free;
    assign is_search = (in_data.op == OP_FIND_FIRST) || (in_data.op == OP_FIND_NEXT);

    assign widx_ext     = CNT_W'(in_data.word_index);
    assign next_idx_ext = CNT_W'(chk_idx_reg) + CNT_W'(1);

    // Only one access kind runs at a time: writes happen in the clear pass or on an idle write,
    // reads on an idle search or while scanning, so no entry is read and written together.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (in_xfer && (in_data.op == OP_WRITE) && (widx_ext < CNT_W'(MAX_WORDS)))
        begin
            mem_we    = 1'b1;
            mem_waddr = widx_ext[AW-1:0];
            mem_wdata = in_data.word_data[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (in_xfer && is_search && (used != '0))
        begin
            rd_en = 1'b1;
        end
        else if (scan_step && (next_idx_ext < used))
        begin
            rd_en   = 1'b1;
            rd_addr = next_idx_ext[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_words[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_words[rd_addr];
        end
    end

    // Mask off bits of the current word that lie below the start position.
    assign rel = $signed(XW'(start_reg)) - $signed(XW'(base_reg));

    always_comb
    begin
        if (rel <= $signed(XW'(0)))
        begin
            start_mask = '1;
        end
        else if (rel >= $signed(XW'(WORD_BITS)))
        begin
            start_mask = '0;
        end
        else
        begin
            start_mask = {WORD_BITS{1'b1}} << rel[SW-1:0];
        end
    end

    assign masked     = rd_data_reg & start_mask;
    assign low_onehot = masked & (~masked + WORD_BITS'(1));

    // Encode the isolated lowest bit; each index bit is an OR over independent positions.
    always_comb
    begin
        bit_idx = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (low_onehot[j])
            begin
                bit_idx = bit_idx | SW'(j);
            end
        end
    end

    assign pos_sum = SUM_W'(base_reg) + SUM_W'(bit_idx);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        chk_idx_next   = chk_idx_reg;
        base_next      = base_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(MAX_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    chk_idx_next = '0;
                    base_next    = '0;
                    start_next   = (in_data.op == OP_FIND_NEXT)
                                   ? START_W'(in_data.prev_bit) + START_W'(1) : '0;
                    if (is_search && (used != '0))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_step)
                begin
                    if (masked != '0)
                    begin
                        state_next                 = S_IDLE;
                        out_valid_next             = 1'b1;
                        out_data_next.found        = 1'b1;
                        out_data_next.bit_position = pos_sum[POS_W-1:0];
                    end
                    else if (next_idx_ext >= used)
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                    end
                    else
                    begin
                        chk_idx_next = next_idx_ext[AW-1:0];
                        base_next    = base_reg + PW'(WORD_BITS);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            word_count_reg <= WORD_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            word_count_reg <= word_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        base_reg     <= base_next;
        start_reg    <= start_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BFN_ASSERT_NOW(a_not_found_zero, out_valid_reg && !out_data_reg.found,
        out_data_reg.bit_position == '0, "not-found result carries a nonzero position")
    `BFN_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN, CNT_W'(chk_idx_reg) < used,
        "scan index beyond words in use")
    `BFN_ASSERT_NOW(a_no_write_in_scan, state_reg == S_SCAN, !mem_we,
        "memory written during a scan")
    `BFN_ASSERT_NEXT(a_search_starts, in_xfer && is_search && (used != '0),
        state_reg == S_SCAN, "search did not enter the scan")

endmodule
